// ===== sv/prjb_pkg.sv =====
// Shared types and constants for the packet reorder jitter buffer.
// Depends on nothing; every other file refers to it by scoped names.
package prjb_pkg;

    // Default ring size and fixed field widths
    localparam int SLOTS_DEF = 32;
    localparam int SEQ_W     = 16;

    // Wait limit: reset value in ms and the ms to us scale
    localparam logic [15:0] WAIT_RESET_MS = 16'd100;
    localparam logic [31:0] US_PER_MS     = 32'd1000;

    // Input word kinds
    localparam logic [1:0] KIND_PUSH     = 2'd0;
    localparam logic [1:0] KIND_POP      = 2'd1;
    localparam logic [1:0] KIND_SHUTDOWN = 2'd2;

    // Result word kinds
    localparam logic [1:0] RES_RELEASED  = 2'd0;
    localparam logic [1:0] RES_FREED     = 2'd1;
    localparam logic [1:0] RES_NOT_READY = 2'd2;
    localparam logic [1:0] RES_EOS       = 2'd3;

    // One result word
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] out_handle;
        logic [15:0] out_seq;
        logic [5:0]  lost_count;
        logic        last;
    } rslt_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_PUSH_DEC,
        ST_RS_READ,
        ST_RS_EMIT,
        ST_RS_DONE,
        ST_PUSH_STORE,
        ST_FREE_NEW,
        ST_POP_START,
        ST_POP_PROBE,
        ST_TO_READ,
        ST_TO_CMP,
        ST_POP_RELEASE,
        ST_POP_FAIL
    } state_t;

endpackage

// ===== sv/packet_reorder_jitter_buffer.sv =====
// Packet reorder jitter buffer, top level. A shutdown or unused word is done in the
// cycle it is accepted. A push waits for the reciprocal modulo unit, then is decided
// and stored, or handed back if late or a duplicate; a push that jumps SLOTS or more
// ahead first walks the ring, reading each slot and freeing each held one, then
// restarts the window. A pop first checks for an empty buffer, then probes the
// expected slot and releases its packet; one that must check the age limit reads and
// compares each slot in turn, and each skipped number is probed anew.
// A result word waiting in the output register stalls the sequencer; input ready
// is high only while no word is in work. Memories need no clearing after reset.
// Depends on prjb_pkg, prjb_rem, prjb_slot_ram and prjb_ctrl.
module packet_reorder_jitter_buffer #(
    parameter int SLOTS = prjb_pkg::SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [15:0] seq,
    input  logic [15:0] packet_handle,
    input  logic [31:0] now_us,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [15:0] out_handle,
    output logic [15:0] out_seq,
    output logic [5:0]  lost_count,
    output logic        last,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    localparam int IDX_W = $clog2(SLOTS);

    logic [31:0]      limit_reg;
    logic             rem_start;
    logic             rem_done;
    logic [IDX_W-1:0] rem_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [15:0]      wr_handle;
    logic [31:0]      wr_arrival;
    logic [IDX_W-1:0] rd_addr;
    logic [15:0]      rd_handle;
    logic [31:0]      rd_arrival;
    prjb_pkg::rslt_t  out_word;

    // Hold the wait limit, kept in microseconds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 32'(prjb_pkg::WAIT_RESET_MS) * prjb_pkg::US_PER_MS;
        end
        else if (cfg_we)
        begin
            limit_reg <= 32'(cfg_wdata) * prjb_pkg::US_PER_MS;
        end
    end

    prjb_rem #(
        .SLOTS (SLOTS)
    ) u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rem_start),
        .value (seq),
        .done  (rem_done),
        .rem   (rem_idx)
    );

    prjb_slot_ram #(
        .SLOTS (SLOTS)
    ) u_ram (
        .clk        (clk),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_handle  (wr_handle),
        .wr_arrival (wr_arrival),
        .rd_addr    (rd_addr),
        .rd_handle  (rd_handle),
        .rd_arrival (rd_arrival)
    );

    prjb_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .seq           (seq),
        .packet_handle (packet_handle),
        .now_us        (now_us),
        .limit         (limit_reg),
        .rem_start     (rem_start),
        .rem_done      (rem_done),
        .rem_idx       (rem_idx),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_handle     (wr_handle),
        .wr_arrival    (wr_arrival),
        .rd_addr       (rd_addr),
        .rd_handle     (rd_handle),
        .rd_arrival    (rd_arrival),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_word      (out_word)
    );

    // Spread the result word over its ports
    assign result_kind = out_word.result_kind;
    assign out_handle  = out_word.out_handle;
    assign out_seq     = out_word.out_seq;
    assign lost_count  = out_word.lost_count;
    assign last        = out_word.last;

endmodule

// ===== sv/prjb_rem.sv =====
// Remainder unit: sequence number modulo the ring size by reciprocal multiplication.
// Product registered on start, remainder in the cycle after with done; uses prjb_pkg.
module prjb_rem #(
    parameter int SLOTS = prjb_pkg::SLOTS_DEF,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [15:0]      value,
    output logic             done,
    output logic [IDX_W-1:0] rem
);

    localparam int                FRAC_W = prjb_pkg::SEQ_W + IDX_W;
    localparam int                PROD_W = prjb_pkg::SEQ_W + FRAC_W;
    localparam logic [FRAC_W-1:0] RECIP  =
        FRAC_W'(((64'd1 << FRAC_W) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

    logic              busy_reg;
    logic              done_reg;
    logic [15:0]       val_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [IDX_W-1:0]  rem_reg;
    logic [15:0]       quot;
    logic [15:0]       back;
    logic [IDX_W-1:0]  rem_next;

    // Quotient from the scaled product, then take back quotient times ring size
    assign quot     = prod_reg[PROD_W-1:FRAC_W];
    assign back     = 16'(quot * 16'(SLOTS));
    assign rem_next = IDX_W'(val_reg - back);

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
            done_reg <= busy_reg;
        end
    end

    // Dividend, scaled product and remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= value;
            prod_reg <= PROD_W'(value) * PROD_W'(RECIP);
        end
        if (busy_reg)
        begin
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== sv/prjb_slot_ram.sv =====
// Slot store: packet handle and arrival time for each ring slot.
// One write port, one read port with registered read data; uses prjb_pkg.
module prjb_slot_ram #(
    parameter int SLOTS = prjb_pkg::SLOTS_DEF,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [15:0]      wr_handle,
    input  logic [31:0]      wr_arrival,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [15:0]      rd_handle,
    output logic [31:0]      rd_arrival
);

    logic [47:0] mem [SLOTS];
    logic [47:0] rd_data_reg;

    // Write a slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_handle, wr_arrival};
        end
    end

    // Read a slot, data in the next cycle
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_handle  = rd_data_reg[47:32];
    assign rd_arrival = rd_data_reg[31:0];

endmodule

// ===== sv/prjb_ctrl.sv =====
// Sequencer of the jitter buffer: slot valid bits, expected number, walks
// over the ring and the result word register. Uses prjb_pkg.
module prjb_ctrl #(
    parameter int SLOTS = prjb_pkg::SLOTS_DEF,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            kind,
    input  logic [15:0]           seq,
    input  logic [15:0]           packet_handle,
    input  logic [31:0]           now_us,
    input  logic [31:0]           limit,
    output logic                  rem_start,
    input  logic                  rem_done,
    input  logic [IDX_W-1:0]      rem_idx,
    output logic                  wr_en,
    output logic [IDX_W-1:0]      wr_addr,
    output logic [15:0]           wr_handle,
    output logic [31:0]           wr_arrival,
    output logic [IDX_W-1:0]      rd_addr,
    input  logic [15:0]           rd_handle,
    input  logic [31:0]           rd_arrival,
    output logic                  out_valid,
    input  logic                  out_ready,
    output prjb_pkg::rslt_t       out_word
);

    localparam int                HELD_W   = $clog2(SLOTS + 1);
    localparam int                STEP_W   = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(SLOTS - 1);

    prjb_pkg::state_t  state_reg, state_next;
    logic [SLOTS-1:0]  valid_reg, valid_next;
    logic [15:0]       next_seq_reg, next_seq_next;
    logic [IDX_W-1:0]  next_idx_reg, next_idx_next;
    logic              started_reg, started_next;
    logic [HELD_W-1:0] held_reg, held_next;
    logic              draining_reg, draining_next;
    logic [IDX_W-1:0]  scan_reg, scan_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [5:0]        lost_reg, lost_next;
    logic              skip_reg, skip_next;
    logic              out_valid_reg;

    logic [15:0]       seq_reg;
    logic [15:0]       handle_reg;
    logic [31:0]       now_reg;
    logic [IDX_W-1:0]  s_idx_reg;
    prjb_pkg::rslt_t   out_word_reg;

    logic              out_free;
    logic              latch_in;
    logic              emit;
    prjb_pkg::rslt_t   emit_word;
    logic              adv;
    logic [15:0]       diff;
    logic [31:0]       age;
    logic [IDX_W-1:0]  idx_inc;
    logic [SLOTS-1:0]  above_mask;

    assign out_free = !out_valid_reg || out_ready;
    assign diff     = seq_reg - (started_reg ? next_seq_reg : seq_reg);
    assign age      = now_reg - rd_arrival;

    // Slot of the expected number plus one: ring wrap, and reset to zero at seq wrap
    always_comb
    begin
        if (next_seq_reg == 16'hFFFF)
        begin
            idx_inc = '0;
        end
        else if (next_idx_reg == LAST_IDX)
        begin
            idx_inc = '0;
        end
        else
        begin
            idx_inc = next_idx_reg + 1'b1;
        end
    end

    // Slots above the scan position, to mark the last freed word of a resync
    always_comb
    begin
        for (int j = 0; j < SLOTS; j++)
        begin
            above_mask[j] = (IDX_W'(j) > scan_reg);
        end
    end

    // Memory ports
    assign rd_addr    = (state_reg == prjb_pkg::ST_POP_PROBE ||
                         state_reg == prjb_pkg::ST_POP_RELEASE) ? next_idx_reg : scan_reg;
    assign wr_addr    = s_idx_reg;
    assign wr_handle  = handle_reg;
    assign wr_arrival = now_reg;

    // Next state and outputs
    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        next_seq_next = next_seq_reg;
        next_idx_next = next_idx_reg;
        started_next  = started_reg;
        held_next     = held_reg;
        draining_next = draining_reg;
        scan_next     = scan_reg;
        step_next     = step_reg;
        lost_next     = lost_reg;
        skip_next     = skip_reg;
        in_ready      = 1'b0;
        latch_in      = 1'b0;
        rem_start     = 1'b0;
        wr_en         = 1'b0;
        emit          = 1'b0;
        emit_word     = '0;
        adv           = 1'b0;

        unique case (state_reg)
            prjb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    latch_in = 1'b1;
                    unique case (kind)
                        prjb_pkg::KIND_PUSH:
                        begin
                            rem_start  = 1'b1;
                            state_next = prjb_pkg::ST_MOD;
                        end
                        prjb_pkg::KIND_POP:
                        begin
                            state_next = prjb_pkg::ST_POP_START;
                        end
                        prjb_pkg::KIND_SHUTDOWN:
                        begin
                            draining_next = 1'b1;
                        end
                        default:
                        begin
                            state_next = prjb_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            // Wait for the slot index of the pushed number
            prjb_pkg::ST_MOD:
            begin
                if (rem_done)
                begin
                    state_next = prjb_pkg::ST_PUSH_DEC;
                end
            end

            // Classify the push: late, far ahead, or in the window
            prjb_pkg::ST_PUSH_DEC:
            begin
                if (!started_reg)
                begin
                    started_next  = 1'b1;
                    next_seq_next = seq_reg;
                    next_idx_next = s_idx_reg;
                end
                if (diff[15])
                begin
                    state_next = prjb_pkg::ST_FREE_NEW;
                end
                else if (diff >= 16'(SLOTS))
                begin
                    scan_next  = '0;
                    state_next = prjb_pkg::ST_RS_READ;
                end
                else
                begin
                    state_next = prjb_pkg::ST_PUSH_STORE;
                end
            end

            // Resync: walk the ring, skip empty slots
            prjb_pkg::ST_RS_READ:
            begin
                if (valid_reg[scan_reg])
                begin
                    state_next = prjb_pkg::ST_RS_EMIT;
                end
                else if (scan_reg == LAST_IDX)
                begin
                    state_next = prjb_pkg::ST_RS_DONE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            // Resync: free one held handle
            prjb_pkg::ST_RS_EMIT:
            begin
                if (out_free)
                begin
                    emit                  = 1'b1;
                    emit_word.result_kind = prjb_pkg::RES_FREED;
                    emit_word.out_handle  = rd_handle;
                    emit_word.last        = ~|(valid_reg & above_mask);
                    valid_next[scan_reg]  = 1'b0;
                    if (scan_reg == LAST_IDX)
                    begin
                        state_next = prjb_pkg::ST_RS_DONE;
                    end
                    else
                    begin
                        scan_next  = scan_reg + 1'b1;
                        state_next = prjb_pkg::ST_RS_READ;
                    end
                end
            end

            // Resync: restart the window at the new packet
            prjb_pkg::ST_RS_DONE:
            begin
                held_next     = '0;
                next_seq_next = seq_reg;
                next_idx_next = s_idx_reg;
                state_next    = prjb_pkg::ST_PUSH_STORE;
            end

            // Store the packet, or hand it back as a duplicate
            prjb_pkg::ST_PUSH_STORE:
            begin
                if (valid_reg[s_idx_reg])
                begin
                    state_next = prjb_pkg::ST_FREE_NEW;
                end
                else
                begin
                    wr_en                 = 1'b1;
                    valid_next[s_idx_reg] = 1'b1;
                    held_next             = held_reg + 1'b1;
                    state_next            = prjb_pkg::ST_IDLE;
                end
            end

            // Hand the pushed handle back
            prjb_pkg::ST_FREE_NEW:
            begin
                if (out_free)
                begin
                    emit                  = 1'b1;
                    emit_word.result_kind = prjb_pkg::RES_FREED;
                    emit_word.out_handle  = handle_reg;
                    emit_word.last        = 1'b1;
                    state_next            = prjb_pkg::ST_IDLE;
                end
            end

            // Pop: empty buffer answers at once
            prjb_pkg::ST_POP_START:
            begin
                if (held_reg == '0)
                begin
                    if (out_free)
                    begin
                        emit                  = 1'b1;
                        emit_word.result_kind = draining_reg ? prjb_pkg::RES_EOS
                                                             : prjb_pkg::RES_NOT_READY;
                        emit_word.last        = 1'b1;
                        state_next            = prjb_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    step_next  = '0;
                    lost_next  = '0;
                    skip_next  = 1'b0;
                    state_next = prjb_pkg::ST_POP_PROBE;
                end
            end

            // Pop: look at the expected slot
            prjb_pkg::ST_POP_PROBE:
            begin
                if (valid_reg[next_idx_reg])
                begin
                    state_next = prjb_pkg::ST_POP_RELEASE;
                end
                else if (skip_reg || draining_reg)
                begin
                    skip_next = 1'b1;
                    adv       = 1'b1;
                end
                else
                begin
                    scan_next  = '0;
                    state_next = prjb_pkg::ST_TO_READ;
                end
            end

            // Age search: read one slot
            prjb_pkg::ST_TO_READ:
            begin
                state_next = prjb_pkg::ST_TO_CMP;
            end

            // Age search: compare its age with the limit
            prjb_pkg::ST_TO_CMP:
            begin
                if (valid_reg[scan_reg] && (age >= limit))
                begin
                    skip_next = 1'b1;
                    adv       = 1'b1;
                end
                else if (scan_reg == LAST_IDX)
                begin
                    state_next = prjb_pkg::ST_POP_FAIL;
                end
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = prjb_pkg::ST_TO_READ;
                end
            end

            // Release the expected packet
            prjb_pkg::ST_POP_RELEASE:
            begin
                if (out_free)
                begin
                    emit                     = 1'b1;
                    emit_word.result_kind    = prjb_pkg::RES_RELEASED;
                    emit_word.out_handle     = rd_handle;
                    emit_word.out_seq        = next_seq_reg;
                    emit_word.lost_count     = lost_reg;
                    emit_word.last           = 1'b1;
                    valid_next[next_idx_reg] = 1'b0;
                    held_next                = held_reg - 1'b1;
                    next_seq_next            = next_seq_reg + 1'b1;
                    next_idx_next            = idx_inc;
                    state_next               = prjb_pkg::ST_IDLE;
                end
            end

            // Nothing to release yet
            prjb_pkg::ST_POP_FAIL:
            begin
                if (out_free)
                begin
                    emit                  = 1'b1;
                    emit_word.result_kind = prjb_pkg::RES_NOT_READY;
                    emit_word.last        = 1'b1;
                    state_next            = prjb_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = prjb_pkg::ST_IDLE;
            end
        endcase

        // Skip one missing number as lost
        if (adv)
        begin
            next_seq_next = next_seq_reg + 1'b1;
            next_idx_next = idx_inc;
            lost_next     = lost_reg + 1'b1;
            if (step_reg == STEP_W'(SLOTS))
            begin
                state_next = prjb_pkg::ST_POP_FAIL;
            end
            else
            begin
                step_next  = step_reg + 1'b1;
                state_next = prjb_pkg::ST_POP_PROBE;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= prjb_pkg::ST_IDLE;
            valid_reg     <= '0;
            next_seq_reg  <= '0;
            next_idx_reg  <= '0;
            started_reg   <= 1'b0;
            held_reg      <= '0;
            draining_reg  <= 1'b0;
            scan_reg      <= '0;
            step_reg      <= '0;
            lost_reg      <= '0;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            next_seq_reg <= next_seq_next;
            next_idx_reg <= next_idx_next;
            started_reg  <= started_next;
            held_reg     <= held_next;
            draining_reg <= draining_next;
            scan_reg     <= scan_next;
            step_reg     <= step_next;
            lost_reg     <= lost_next;
            skip_reg     <= skip_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: input word, slot index, result word
    always_ff @(posedge clk)
    begin
        if (latch_in)
        begin
            seq_reg    <= seq;
            handle_reg <= packet_handle;
            now_reg    <= now_us;
        end
        if (state_reg == prjb_pkg::ST_MOD && rem_done)
        begin
            s_idx_reg <= rem_idx;
        end
        if (emit)
        begin
            out_word_reg <= emit_word;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// ===== sv/prjb_checker.sv =====
// Port-level checks for the jitter buffer and the bind that attaches them.
// Depends on prjb_pkg and packet_reorder_jitter_buffer.
module prjb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  kind,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  result_kind,
    input logic [15:0] out_handle,
    input logic [15:0] out_seq,
    input logic [5:0]  lost_count,
    input logic        last
);

    // A push or pop keeps the block busy for at least the next cycle
    a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready &&
        (kind == prjb_pkg::KIND_PUSH || kind == prjb_pkg::KIND_POP) |=> !in_ready)
        else $error("input taken while a push or pop is in work");

    // An idle block produces no word of its own
    a_no_spont_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && !out_valid |=> !out_valid)
        else $error("result word appeared with no work in progress");

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
        $stable(out_handle) && $stable(out_seq) && $stable(lost_count) && $stable(last))
        else $error("stalled result word changed");

    // Status replies carry no handle and end the item
    a_reply_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == prjb_pkg::RES_NOT_READY ||
                      result_kind == prjb_pkg::RES_EOS) |->
        out_handle == 16'd0 && out_seq == 16'd0 && lost_count == 6'd0 && last)
        else $error("malformed status reply");

    // Freed handles carry no sequence number or loss count
    a_freed_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == prjb_pkg::RES_FREED |->
        out_seq == 16'd0 && lost_count == 6'd0)
        else $error("malformed freed word");

endmodule

bind packet_reorder_jitter_buffer prjb_checker u_prjb_checker (.*);

// ===== dv/packet_reorder_jitter_buffer_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for packet_reorder_jitter_buffer: directed and random words
// against an in-bench prediction of the reorder ring. Depends on prjb_pkg and the RTL.
module packet_reorder_jitter_buffer_test;

    localparam int          RING       = prjb_pkg::SLOTS_DEF;
    localparam int          SETTLE_CYC = 120;
    localparam int          HOLD_CYC   = 300;
    localparam int          QUIET_MAX  = 3000;
    localparam logic [1:0]  KIND_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  kind;
    logic [15:0] seq;
    logic [15:0] packet_handle;
    logic [31:0] now_us;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  result_kind;
    logic [15:0] out_handle;
    logic [15:0] out_seq;
    logic [5:0]  lost_count;
    logic        last;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    // Ring image kept in step with every accepted word
    logic [15:0] held_hdl  [RING];
    bit          held_flag [RING];
    logic [31:0] held_time [RING];
    logic [15:0] ring_next;
    bit          ring_started;
    int          held_total;
    bit          ring_draining;
    logic [15:0] wait_ms;

    // Result words still owed by the block, oldest first
    prjb_pkg::rslt_t due_words[$];

    int          mismatches;
    int          words_taken;
    int          results_seen;
    int          quiet_cycles;
    bit          tx_idle_en;
    bit          rx_idle_en;
    bit          rx_hold_req;
    logic [31:0] clock_us;
    logic [15:0] stream_pos;

    packet_reorder_jitter_buffer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .seq           (seq),
        .packet_handle (packet_handle),
        .now_us        (now_us),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .out_handle    (out_handle),
        .out_seq       (out_seq),
        .lost_count    (lost_count),
        .last          (last),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Queue one owed result word
    function automatic void add_due(logic [1:0] rk, logic [15:0] h, logic [15:0] s,
                                    logic [5:0] lost);
        prjb_pkg::rslt_t w;
        w.result_kind = rk;
        w.out_handle  = h;
        w.out_seq     = s;
        w.lost_count  = lost;
        w.last        = 1'b0;
        due_words.push_back(w);
    endfunction

    // True when some held packet has waited the full limit
    function automatic bit ring_aged(logic [31:0] t);
        logic [31:0] limit;
        logic [31:0] age;
        limit = {16'h0000, wait_ms} * 32'd1000;
        for (int i = 0; i < RING; i++)
        begin
            age = t - held_time[i];
            if (held_flag[i] && age >= limit)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Store a pushed packet, or hand back what the push displaces
    function automatic void ring_push(logic [15:0] s, logic [15:0] h, logic [31:0] t);
        logic [15:0] ahead;
        int          idx;
        if (!ring_started)
        begin
            ring_next    = s;
            ring_started = 1'b1;
        end
        ahead = s - ring_next;
        if (ahead >= 16'h8000)
        begin
            add_due(prjb_pkg::RES_FREED, h, 16'h0, 6'h0);
            return;
        end
        // Resync: free every held handle in slot order
        if (ahead >= RING)
        begin
            for (int i = 0; i < RING; i++)
            begin
                if (held_flag[i])
                begin
                    add_due(prjb_pkg::RES_FREED, held_hdl[i], 16'h0, 6'h0);
                    held_flag[i] = 1'b0;
                end
            end
            held_total = 0;
            ring_next  = s;
        end
        idx = s % RING;
        if (held_flag[idx])
        begin
            add_due(prjb_pkg::RES_FREED, h, 16'h0, 6'h0);
            return;
        end
        held_flag[idx] = 1'b1;
        held_hdl[idx]  = h;
        held_time[idx] = t;
        held_total++;
    endfunction

    // Release the expected packet, skipping lost numbers when allowed
    function automatic void ring_pop(logic [31:0] t);
        int lost;
        bit skipping;
        int idx;
        if (held_total == 0)
        begin
            add_due(ring_draining ? prjb_pkg::RES_EOS : prjb_pkg::RES_NOT_READY,
                    16'h0, 16'h0, 6'h0);
            return;
        end
        lost     = 0;
        skipping = 1'b0;
        for (int step = 0; step <= RING; step++)
        begin
            idx = ring_next % RING;
            if (held_flag[idx])
            begin
                held_flag[idx] = 1'b0;
                held_total--;
                add_due(prjb_pkg::RES_RELEASED, held_hdl[idx], ring_next, 6'(lost));
                ring_next = ring_next + 16'd1;
                return;
            end
            if (!skipping)
            begin
                if (!(ring_draining || ring_aged(t)))
                begin
                    add_due(prjb_pkg::RES_NOT_READY, 16'h0, 16'h0, 6'h0);
                    return;
                end
                skipping = 1'b1;
            end
            ring_next = ring_next + 16'd1;
            lost++;
        end
        add_due(prjb_pkg::RES_NOT_READY, 16'h0, 16'h0, 6'h0);
    endfunction

    // Check result words, then predict from the input word taken at this edge
    always @(posedge clk)
    begin : word_monitor
        prjb_pkg::rslt_t want;
        prjb_pkg::rslt_t got;
        int              n_before;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.result_kind = result_kind;
                got.out_handle  = out_handle;
                got.out_seq     = out_seq;
                got.lost_count  = lost_count;
                got.last        = last;
                results_seen++;
                if (due_words.size() == 0)
                begin
                    $error("unexpected result word: kind %0d handle %0h seq %0h",
                           got.result_kind, got.out_handle, got.out_seq);
                    mismatches++;
                end
                else
                begin
                    want = due_words.pop_front();
                    if (got.result_kind !== want.result_kind)
                    begin
                        $error("result_kind: expected %0d, got %0d",
                               want.result_kind, got.result_kind);
                        mismatches++;
                    end
                    if (got.out_handle !== want.out_handle)
                    begin
                        $error("out_handle: expected %0h, got %0h",
                               want.out_handle, got.out_handle);
                        mismatches++;
                    end
                    if (got.out_seq !== want.out_seq)
                    begin
                        $error("out_seq: expected %0h, got %0h", want.out_seq, got.out_seq);
                        mismatches++;
                    end
                    if (got.lost_count !== want.lost_count)
                    begin
                        $error("lost_count: expected %0d, got %0d",
                               want.lost_count, got.lost_count);
                        mismatches++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, got.last);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
                wait_ms = cfg_wdata;
            if (in_valid && in_ready)
            begin
                words_taken++;
                n_before = due_words.size();
                case (kind)
                    prjb_pkg::KIND_PUSH:     ring_push(seq, packet_handle, now_us);
                    prjb_pkg::KIND_POP:      ring_pop(now_us);
                    prjb_pkg::KIND_SHUTDOWN: ring_draining = 1'b1;
                    default:                 ;
                endcase
                // Flag the final word of this item
                if (due_words.size() > n_before)
                begin
                    want      = due_words.pop_back();
                    want.last = 1'b1;
                    due_words.push_back(want);
                end
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_MAX)
        begin
            $display("packet_reorder_jitter_buffer_test: FAIL");
            $finish;
        end
    end

    function automatic int draw_gap(bit en);
        return en ? int'($urandom_range(0, 19)) : 0;
    endfunction

    // Take result words, with random stalls and an optional long hold-off
    initial
    begin : result_sink
        int gap;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYC) @(posedge clk);
                rx_hold_req = 1'b0;
            end
            gap = draw_gap(rx_idle_en);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Offer one input word and hold it until taken
    task automatic send_word(input logic [1:0] k, input logic [15:0] s,
                             input logic [15:0] h, input logic [31:0] t);
        int gap;
        gap = draw_gap(tx_idle_en);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= k;
        seq           <= s;
        packet_handle <= h;
        now_us        <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stop offering, wait for every owed word, then let the block go idle
    task automatic settle_ring();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic set_wait_limit(input logic [15:0] ms);
        cfg_we    <= 1'b1;
        cfg_wdata <= ms;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Mixed traffic around a moving stream position
    task automatic random_traffic(input int n_items, input bit with_shutdown);
        int          taken;
        int          pick;
        logic [31:0] t;
        taken = 0;
        while (taken < n_items)
        begin
            pick     = $urandom_range(0, 99);
            clock_us = clock_us + $urandom_range(0, 4000);
            if ($urandom_range(0, 7) == 0)
                clock_us = clock_us + $urandom_range(20000, 400000);
            t = ($urandom_range(0, 29) == 0) ? $urandom : clock_us;
            if (pick < 3)
                send_word(KIND_UNUSED, 16'($urandom), 16'($urandom), t);
            else
            begin
                taken++;
                if (pick < 43)
                    send_word(prjb_pkg::KIND_POP, 16'($urandom), 16'($urandom), t);
                else if (pick < 48)
                    send_word(prjb_pkg::KIND_PUSH,
                              16'(stream_pos - $urandom_range(40, 32000)),
                              16'($urandom), t);
                else if (pick < 52)
                begin
                    stream_pos = 16'(stream_pos + $urandom_range(32, 32767));
                    send_word(prjb_pkg::KIND_PUSH, stream_pos, 16'($urandom), t);
                end
                else if (with_shutdown && pick < 56)
                    send_word(prjb_pkg::KIND_SHUTDOWN, 16'($urandom), 16'($urandom), t);
                else
                begin
                    send_word(prjb_pkg::KIND_PUSH,
                              16'(stream_pos + $urandom_range(0, 8) - 2),
                              16'($urandom), t);
                    if ($urandom_range(0, 4) != 0)
                        stream_pos = stream_pos + 16'd1;
                end
            end
        end
    endtask

    // Empty pop, first push, late and duplicate words, wrap, timeout skip, resync
    task automatic test_directed_order();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_word(prjb_pkg::KIND_POP, 16'h0000, 16'h0000, 32'h0000_0000);
        send_word(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(prjb_pkg::KIND_PUSH, 16'hFFFE, 16'hFFFF, 32'hFFFF_FF00);
        send_word(prjb_pkg::KIND_PUSH, 16'h0001, 16'h0001, 32'hFFFF_FF00);
        send_word(prjb_pkg::KIND_PUSH, 16'hFFFD, 16'h1234, 32'hFFFF_FF00);
        send_word(prjb_pkg::KIND_PUSH, 16'hFFFE, 16'h0000, 32'hFFFF_FF00);
        send_word(prjb_pkg::KIND_POP, 16'h0000, 16'h0000, 32'hFFFF_FF00);
        // Age just short of the limit across the time wrap, then exactly at it
        send_word(prjb_pkg::KIND_POP, 16'h0000, 16'h0000, 32'h0000_02E8);
        send_word(prjb_pkg::KIND_POP, 16'h0000, 16'h0000, 32'h0001_8000);
        send_word(prjb_pkg::KIND_POP, 16'h0000, 16'h0000, 32'h0001_85A0);
        // Fill up to a window of 31, then jump by 32, 0x7FFF and 0x8000
        send_word(prjb_pkg::KIND_PUSH, 16'h0010, 16'hA5A5, 32'h0002_0000);
        send_word(prjb_pkg::KIND_PUSH, 16'h0020, 16'h5A5A, 32'h0002_0000);
        send_word(prjb_pkg::KIND_PUSH, 16'h0021, 16'h0F0F, 32'h0002_0000);
        send_word(prjb_pkg::KIND_PUSH, 16'h0022, 16'hF0F0, 32'h0002_0000);
        send_word(prjb_pkg::KIND_PUSH, 16'h8021, 16'h8001, 32'h0002_0000);
        send_word(prjb_pkg::KIND_PUSH, 16'h0021, 16'h7FFE, 32'h0002_0000);
        settle_ring();
    endtask

    // Zero, largest and one-millisecond wait limits, each at its boundary
    task automatic test_wait_limits();
        set_wait_limit(16'd0);
        clock_us = 32'h0003_0000;
        send_word(prjb_pkg::KIND_PUSH, 16'h8023, 16'h1111, clock_us);
        send_word(prjb_pkg::KIND_POP, 16'h0000, 16'h0000, clock_us);
        send_word(prjb_pkg::KIND_POP, 16'h0000, 16'h0000, clock_us);
        settle_ring();
        set_wait_limit(16'hFFFF);
        send_word(prjb_pkg::KIND_PUSH, 16'h8025, 16'h2222, clock_us);
        send_word(prjb_pkg::KIND_POP, 16'h0000, 16'h0000, clock_us + 32'd65_534_999);
        send_word(prjb_pkg::KIND_POP, 16'h0000, 16'h0000, clock_us + 32'd65_535_000);
        settle_ring();
        set_wait_limit(16'd1);
        clock_us = clock_us + 32'd65_535_000;
        send_word(prjb_pkg::KIND_PUSH, 16'h8027, 16'h3333, clock_us);
        send_word(prjb_pkg::KIND_POP, 16'h0000, 16'h0000, clock_us + 32'd999);
        send_word(prjb_pkg::KIND_POP, 16'h0000, 16'h0000, clock_us + 32'd1000);
        clock_us = clock_us + 32'd1000;
        settle_ring();
    endtask

    // Random traffic under several wait limits and idling patterns
    task automatic test_random_traffic();
        stream_pos = ring_next;
        set_wait_limit(prjb_pkg::WAIT_RESET_MS);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        random_traffic(20, 1'b0);
        settle_ring();
        set_wait_limit(16'($urandom_range(2, 400)));
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        random_traffic(20, 1'b0);
        settle_ring();
        set_wait_limit(16'hFFFF);
        rx_idle_en = 1'b0;
        random_traffic(20, 1'b0);
        settle_ring();
        set_wait_limit(prjb_pkg::WAIT_RESET_MS);
        rx_idle_en = 1'b1;
    endtask

    // Fill every slot, then free all of them while the receiver holds off
    task automatic test_ring_overflow();
        logic [15:0] anchor;
        logic [15:0] order [RING];
        logic [15:0] tmp;
        int          j;
        anchor = ring_next + 16'd40;
        for (int i = 0; i < RING; i++)
            order[i] = anchor + 16'(i);
        for (int i = 1; i < RING - 1; i++)
        begin
            j        = $urandom_range(i, RING - 1);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < RING; i++)
            send_word(prjb_pkg::KIND_PUSH, order[i], 16'($urandom), clock_us);
        rx_hold_req = 1'b1;
        send_word(prjb_pkg::KIND_PUSH, 16'(anchor + 32 + $urandom_range(0, 1000)),
                  16'($urandom), clock_us);
        for (int i = 0; i < 12; i++)
        begin
            clock_us = clock_us + $urandom_range(0, 50000);
            send_word(prjb_pkg::KIND_POP, 16'($urandom), 16'($urandom), clock_us);
        end
        settle_ring();
    endtask

    // Shutdown: skip without timeout, widest loss, end of stream, then traffic
    task automatic test_draining();
        logic [15:0] m;
        m = ring_next + 16'd40;
        send_word(prjb_pkg::KIND_PUSH, m, 16'h4444, clock_us);
        send_word(prjb_pkg::KIND_PUSH, m + 16'd3, 16'h5555, clock_us);
        send_word(prjb_pkg::KIND_PUSH, m + 16'd31, 16'h6666, clock_us);
        send_word(prjb_pkg::KIND_SHUTDOWN, 16'h0000, 16'h0000, clock_us);
        repeat (4) send_word(prjb_pkg::KIND_POP, 16'h0000, 16'h0000, clock_us);
        send_word(KIND_UNUSED, 16'h0000, 16'h0000, clock_us);
        send_word(prjb_pkg::KIND_SHUTDOWN, 16'hFFFF, 16'hFFFF, clock_us);
        stream_pos = ring_next;
        random_traffic(15, 1'b1);
        send_word(prjb_pkg::KIND_POP, 16'h0000, 16'h0000, clock_us);
        settle_ring();
    endtask

    initial
    begin
        mismatches    = 0;
        words_taken   = 0;
        results_seen  = 0;
        quiet_cycles  = 0;
        tx_idle_en    = 1'b1;
        rx_idle_en    = 1'b1;
        rx_hold_req   = 1'b0;
        clock_us      = 32'h0;
        stream_pos    = 16'h0;
        for (int i = 0; i < RING; i++)
        begin
            held_flag[i] = 1'b0;
            held_hdl[i]  = 16'h0;
            held_time[i] = 32'h0;
        end
        ring_next     = 16'h0;
        ring_started  = 1'b0;
        held_total    = 0;
        ring_draining = 1'b0;
        wait_ms       = prjb_pkg::WAIT_RESET_MS;

        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        kind          <= prjb_pkg::KIND_PUSH;
        seq           <= 16'h0;
        packet_handle <= 16'h0;
        now_us        <= 32'h0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= 16'h0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_order();
        test_wait_limits();
        test_random_traffic();
        test_ring_overflow();
        test_draining();

        $display("Run covered ordered release, late and duplicate handback, resync, "
                 , "timeout and drain skipping, a full ring and output back-pressure.");
        $display("%0d input words taken, %0d result words checked, %0d mismatches.",
                 words_taken, results_seen, mismatches);
        if (mismatches == 0)
            $display("packet_reorder_jitter_buffer_test: PASS");
        else
            $display("packet_reorder_jitter_buffer_test: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
sv/prjb_pkg.sv
sv/prjb_rem.sv
sv/prjb_slot_ram.sv
sv/prjb_ctrl.sv
sv/packet_reorder_jitter_buffer.sv
sv/prjb_checker.sv
dv/packet_reorder_jitter_buffer_test.sv
